/* sv/lfu_pkg.sv */
// Shared constants and types for the LFU slot replacement block.
`default_nettype none

package lfu_pkg;

   localparam int SLOTS_DEF   = 16;
   localparam int ID_BITS_DEF = 8;

   localparam int                USE_W   = 16;
   localparam logic [USE_W-1:0]  USE_MAX = 16'hFFFF;
   localparam logic [USE_W-1:0]  USE_ONE = 16'd1;

   localparam int OUT_ID_W = 8;

   localparam int               LIM_W   = 5;
   localparam logic [LIM_W-1:0] LIM_RST = 5'd16;

   localparam int   CSR_AW         = 3;
   localparam int   CSR_DW         = 32;
   localparam logic CSR_IDX_LIMIT  = 1'b0;

   localparam logic FUNC_REF  = 1'b0;
   localparam logic FUNC_LIST = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_AGE,
      ST_LIST,
      ST_EMIT
   } lfu_state_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic has_prev;
   } sel_ctl_type;

endpackage

`default_nettype wire

/* sv/lfu_mem.sv */
// Single-port-write, single-port-read slot memory with registered read data.
`default_nettype none

module lfu_mem #(
   parameter  int DEPTH = 16,
   parameter  int WIDTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/lfu_sel.sv */
// Scan accumulator: id match, least-used/oldest victim and next ascending id.
`default_nettype none

module lfu_sel #(
   parameter int ID_W  = 8,
   parameter int AGE_W = 4,
   parameter int IDX_W = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lfu_pkg::sel_ctl_type      ctl,
   input  wire logic [IDX_W-1:0]          idx,
   input  wire logic [ID_W-1:0]           ident,
   input  wire logic [lfu_pkg::USE_W-1:0] uses,
   input  wire logic [AGE_W-1:0]          age,
   input  wire logic [ID_W-1:0]           key,
   input  wire logic [ID_W-1:0]           prev,
   output logic                           match_ff,
   output logic [IDX_W-1:0]               match_idx_ff,
   output logic [lfu_pkg::USE_W-1:0]      match_uses_ff,
   output logic [AGE_W-1:0]               match_age_ff,
   output logic [IDX_W-1:0]               vic_idx_ff,
   output logic [lfu_pkg::USE_W-1:0]      vic_uses_ff,
   output logic [AGE_W-1:0]               vic_age_ff,
   output logic [ID_W-1:0]                vic_ident_ff,
   output logic [ID_W-1:0]                min_ff
);

   logic min_found_ff;
   logic match_in;
   logic min_found_in;
   logic m_hit;
   logic v_take;
   logic n_take;
   logic found_base;
   logic elig;

   always_comb begin
      m_hit        = ctl.vld && (ident == key);
      v_take       = ctl.vld && (ctl.first || (uses < vic_uses_ff) ||
                     ((uses == vic_uses_ff) && (age < vic_age_ff)));
      elig         = !ctl.has_prev || (ident > prev);
      found_base   = ctl.first ? 1'b0 : min_found_ff;
      n_take       = ctl.vld && elig && (!found_base || (ident < min_ff));
      match_in     = match_ff;
      min_found_in = min_found_ff;
      if (ctl.vld) begin
         match_in     = (ctl.first ? 1'b0 : match_ff) | m_hit;
         min_found_in = found_base | n_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff     <= 1'b0;
         min_found_ff <= 1'b0;
      end else begin
         match_ff     <= match_in;
         min_found_ff <= min_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_hit) begin
         match_idx_ff  <= idx;
         match_uses_ff <= uses;
         match_age_ff  <= age;
      end
      if (v_take) begin
         vic_idx_ff   <= idx;
         vic_uses_ff  <= uses;
         vic_age_ff   <= age;
         vic_ident_ff <= ident;
      end
      if (n_take) begin
         min_ff <= ident;
      end
   end

endmodule

`default_nettype wire

/* sv/lfu_slot_replacement.sv */
// LFU slot replacement top level: control sequencer, register port, result words.
//
// A reference makes one scan of the occupied slots on a hit or a fill (none on an empty
// table) and a second pass on an eviction (one scan for match and victim, one pass that
// rewrites the age ranks). A list op makes one pass over the slots per emitted id; a list
// on an empty table answers with a single last word and no pass. The slot memory has a
// single read port and is read one entry per cycle. busy stays high until the last word
// of an item is out, result words appear for one cycle on rsp_strobe and cannot be held
// off.
`default_nettype none

module lfu_slot_replacement #(
   parameter int SLOTS   = lfu_pkg::SLOTS_DEF,
   parameter int ID_BITS = lfu_pkg::ID_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_func,
   input  wire logic [7:0]                   req_ref_id,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic                              rsp_evicted,
   output logic [lfu_pkg::OUT_ID_W-1:0]      rsp_evicted_id,
   output logic [lfu_pkg::OUT_ID_W-1:0]      rsp_list_id,
   output logic                              rsp_list_valid,
   output logic                              rsp_last,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lfu_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [lfu_pkg::CSR_DW-1:0]   pwdata,
   output logic [lfu_pkg::CSR_DW-1:0]        prdata,
   output logic                              pready
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AGE_W  = IDX_W;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > lfu_pkg::LIM_W) ? CNT_W : lfu_pkg::LIM_W;
   localparam int WORD_W = ID_BITS + lfu_pkg::USE_W + AGE_W;

   lfu_pkg::lfu_state_type state_ff, state_in;

   logic [lfu_pkg::LIM_W-1:0] limit_ff, limit_in;
   logic [ID_BITS-1:0]        key_ff, key_in;
   logic [ID_BITS-1:0]        prev_ff, prev_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          iss_ff, iss_in;
   logic [CNT_W-1:0]          round_ff, round_in;
   logic                      rvld_ff, rvld_in;
   logic                      rlast_ff, rlast_in;
   logic [IDX_W-1:0]          ridx_ff, ridx_in;

   logic                          stb_ff, stb_in;
   logic                          hit_ff, hit_in;
   logic                          ev_ff, ev_in;
   logic [lfu_pkg::OUT_ID_W-1:0]  evid_ff, evid_in;
   logic [lfu_pkg::OUT_ID_W-1:0]  lid_ff, lid_in;
   logic                          lval_ff, lval_in;
   logic                          last_ff, last_in;

   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  rdata;

   logic [ID_BITS-1:0]         r_ident;
   logic [lfu_pkg::USE_W-1:0]  r_uses;
   logic [AGE_W-1:0]           r_age;

   lfu_pkg::sel_ctl_type       sel_ctl;
   logic                       match;
   logic [IDX_W-1:0]           match_idx;
   logic [lfu_pkg::USE_W-1:0]  match_uses;
   logic [AGE_W-1:0]           match_age;
   logic [IDX_W-1:0]           vic_idx;
   logic [lfu_pkg::USE_W-1:0]  vic_uses;
   logic [AGE_W-1:0]           vic_age;
   logic [ID_BITS-1:0]         vic_ident;
   logic [ID_BITS-1:0]         min_id;

   logic [CMP_W-1:0]           lim_raw;
   logic [CMP_W-1:0]           lim_eff;
   logic                       room;
   logic [lfu_pkg::USE_W-1:0]  uses_inc;
   logic                       csr_wr;

   assign r_ident = rdata[WORD_W-1 -: ID_BITS];
   assign r_uses  = rdata[AGE_W +: lfu_pkg::USE_W];
   assign r_age   = rdata[AGE_W-1:0];

   assign busy = (state_ff != lfu_pkg::ST_IDLE);

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[lfu_pkg::CSR_AW-1] == lfu_pkg::CSR_IDX_LIMIT) ?
                   lfu_pkg::CSR_DW'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr && (paddr[lfu_pkg::CSR_AW-1] == lfu_pkg::CSR_IDX_LIMIT)) begin
         limit_in = pwdata[lfu_pkg::LIM_W-1:0];
      end
   end

   always_comb begin
      lim_raw = CMP_W'(limit_ff);
      if (lim_raw == '0) begin
         lim_eff = CMP_W'(1);
      end else if (lim_raw > CMP_W'(SLOTS)) begin
         lim_eff = CMP_W'(SLOTS);
      end else begin
         lim_eff = lim_raw;
      end
      room     = CMP_W'(occ_ff) < lim_eff;
      uses_inc = (match_uses == lfu_pkg::USE_MAX) ? lfu_pkg::USE_MAX :
                 lfu_pkg::USE_W'(match_uses + lfu_pkg::USE_ONE);
   end

   always_comb begin
      rd_en = ((state_ff == lfu_pkg::ST_SCAN) || (state_ff == lfu_pkg::ST_AGE) ||
               (state_ff == lfu_pkg::ST_LIST)) && (iss_ff < occ_ff);
      rvld_in  = rd_en;
      ridx_in  = iss_ff[IDX_W-1:0];
      rlast_in = (CNT_W'(iss_ff + 1'b1) == occ_ff);

      sel_ctl.vld      = rvld_ff && ((state_ff == lfu_pkg::ST_SCAN) ||
                                     (state_ff == lfu_pkg::ST_LIST));
      sel_ctl.first    = (ridx_ff == '0);
      sel_ctl.has_prev = (round_ff != '0);
   end

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      prev_in  = prev_ff;
      occ_in   = occ_ff;
      iss_in   = rd_en ? CNT_W'(iss_ff + 1'b1) : iss_ff;
      round_in = round_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      stb_in   = 1'b0;
      hit_in   = 1'b0;
      ev_in    = 1'b0;
      evid_in  = '0;
      lid_in   = '0;
      lval_in  = 1'b0;
      last_in  = 1'b0;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (start) begin
               iss_in   = '0;
               round_in = '0;
               if (req_func == lfu_pkg::FUNC_LIST) begin
                  if (occ_ff == '0) begin
                     stb_in  = 1'b1;
                     last_in = 1'b1;
                  end else begin
                     state_in = lfu_pkg::ST_LIST;
                  end
               end else begin
                  key_in   = ID_BITS'(req_ref_id);
                  state_in = (occ_ff == '0) ? lfu_pkg::ST_DECIDE : lfu_pkg::ST_SCAN;
               end
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (rvld_ff && rlast_ff) begin
               state_in = lfu_pkg::ST_DECIDE;
            end
         end
         lfu_pkg::ST_DECIDE: begin
            if ((occ_ff != '0) && match) begin
               wr_en    = 1'b1;
               wr_addr  = match_idx;
               wr_data  = {key_ff, uses_inc, match_age};
               stb_in   = 1'b1;
               hit_in   = 1'b1;
               last_in  = 1'b1;
               state_in = lfu_pkg::ST_IDLE;
            end else if (room) begin
               wr_en    = 1'b1;
               wr_addr  = occ_ff[IDX_W-1:0];
               wr_data  = {key_ff, lfu_pkg::USE_ONE, AGE_W'(occ_ff)};
               occ_in   = CNT_W'(occ_ff + 1'b1);
               stb_in   = 1'b1;
               last_in  = 1'b1;
               state_in = lfu_pkg::ST_IDLE;
            end else begin
               iss_in   = '0;
               state_in = lfu_pkg::ST_AGE;
            end
         end
         lfu_pkg::ST_AGE: begin
            if (rvld_ff) begin
               if (ridx_ff == vic_idx) begin
                  wr_en   = 1'b1;
                  wr_addr = ridx_ff;
                  wr_data = {key_ff, lfu_pkg::USE_ONE, AGE_W'(occ_ff - 1'b1)};
               end else if (r_age > vic_age) begin
                  wr_en   = 1'b1;
                  wr_addr = ridx_ff;
                  wr_data = {r_ident, r_uses, AGE_W'(r_age - 1'b1)};
               end
               if (rlast_ff) begin
                  stb_in   = 1'b1;
                  ev_in    = 1'b1;
                  evid_in  = lfu_pkg::OUT_ID_W'(vic_ident);
                  last_in  = 1'b1;
                  state_in = lfu_pkg::ST_IDLE;
               end
            end
         end
         lfu_pkg::ST_LIST: begin
            if (rvld_ff && rlast_ff) begin
               state_in = lfu_pkg::ST_EMIT;
            end
         end
         lfu_pkg::ST_EMIT: begin
            stb_in   = 1'b1;
            lid_in   = lfu_pkg::OUT_ID_W'(min_id);
            lval_in  = 1'b1;
            last_in  = (CNT_W'(round_ff + 1'b1) == occ_ff);
            prev_in  = min_id;
            round_in = CNT_W'(round_ff + 1'b1);
            iss_in   = '0;
            state_in = last_in ? lfu_pkg::ST_IDLE : lfu_pkg::ST_LIST;
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         limit_ff <= lfu_pkg::LIM_RST;
         occ_ff   <= '0;
         iss_ff   <= '0;
         round_ff <= '0;
         rvld_ff  <= 1'b0;
         stb_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         occ_ff   <= occ_in;
         iss_ff   <= iss_in;
         round_ff <= round_in;
         rvld_ff  <= rvld_in;
         stb_ff   <= stb_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      prev_ff  <= prev_in;
      ridx_ff  <= ridx_in;
      rlast_ff <= rlast_in;
      hit_ff   <= hit_in;
      ev_ff    <= ev_in;
      evid_ff  <= evid_in;
      lid_ff   <= lid_in;
      lval_ff  <= lval_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe     = stb_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_evicted    = ev_ff;
   assign rsp_evicted_id = evid_ff;
   assign rsp_list_id    = lid_ff;
   assign rsp_list_valid = lval_ff;
   assign rsp_last       = last_ff;

   lfu_mem #(
      .DEPTH (SLOTS),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (iss_ff[IDX_W-1:0]),
      .rd_data_ff (rdata)
   );

   lfu_sel #(
      .ID_W  (ID_BITS),
      .AGE_W (AGE_W),
      .IDX_W (IDX_W)
   ) u_sel (
      .clock         (clock),
      .reset         (reset),
      .ctl           (sel_ctl),
      .idx           (ridx_ff),
      .ident         (r_ident),
      .uses          (r_uses),
      .age           (r_age),
      .key           (key_ff),
      .prev          (prev_ff),
      .match_ff      (match),
      .match_idx_ff  (match_idx),
      .match_uses_ff (match_uses),
      .match_age_ff  (match_age),
      .vic_idx_ff    (vic_idx),
      .vic_uses_ff   (vic_uses),
      .vic_age_ff    (vic_age),
      .vic_ident_ff  (vic_ident),
      .min_ff        (min_id)
   );

endmodule

`default_nettype wire

/* sv/lfu_chk.sv */
// Port-level checker for the LFU slot replacement block, with its bind.
`default_nettype none

module lfu_chk (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_hit,
   input wire logic                         rsp_evicted,
   input wire logic [lfu_pkg::OUT_ID_W-1:0] rsp_evicted_id,
   input wire logic                         rsp_list_valid,
   input wire logic                         rsp_last
);

   // an accepted word either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted word produced neither busy nor a result");

   // more words pending exactly when this one is not the last
   a_last_vs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy != rsp_last))
      else $error("last flag disagrees with busy");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction in one result");

   a_list_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_list_valid) |-> (!rsp_hit && !rsp_evicted))
      else $error("list result carries reference flags");

   a_evid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_evicted) |-> (rsp_evicted_id == '0))
      else $error("evicted id set without eviction");

endmodule

bind lfu_slot_replacement lfu_chk u_lfu_chk (.*);

`default_nettype wire

/* tb/tb_lfu_slot_replacement.sv */
// Self-checking testbench for the LFU slot replacement block: directed table, random phases.
`timescale 1ns / 100ps

module tb_lfu_slot_replacement;

   localparam int SLOTS      = lfu_pkg::SLOTS_DEF;
   localparam int CYC_LIMIT  = 200_000;
   localparam int TAIL_WAIT  = 300;

   localparam logic CSR_IDX_SPARE = 1'b1;
   localparam logic [lfu_pkg::CSR_AW-1:0] ADDR_LIMIT = {lfu_pkg::CSR_IDX_LIMIT, 2'b00};
   localparam logic [lfu_pkg::CSR_AW-1:0] ADDR_SPARE = {CSR_IDX_SPARE, 2'b00};

   typedef struct packed {
      logic       hit;
      logic       evicted;
      logic [7:0] evicted_id;
      logic [7:0] list_id;
      logic       list_valid;
      logic       last;
   } rsp_word_type;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic                          func;
      logic [7:0]                    id;
      logic [lfu_pkg::CSR_AW-1:0]    addr;
      logic [lfu_pkg::CSR_DW-1:0]    data;
      logic                          pin;
      rsp_word_type                  want;
   } dir_row_type;

   localparam rsp_word_type W_PLAIN = '{1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1};
   localparam rsp_word_type W_FILL  = W_PLAIN;
   localparam rsp_word_type W_EMPTY = W_PLAIN;
   localparam rsp_word_type W_HIT   = '{1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1};
   localparam rsp_word_type W_EV255 = '{1'b0, 1'b1, 8'd255, 8'd0, 1'b0, 1'b1};

   localparam logic F_REF  = lfu_pkg::FUNC_REF;
   localparam logic F_LIST = lfu_pkg::FUNC_LIST;

   localparam int N_DIR = 21;
   localparam dir_row_type DIR_TAB [N_DIR] = '{
      '{ROW_ITEM,  F_LIST, 8'd0,   ADDR_LIMIT, 32'd0,         1'b1, W_EMPTY},
      '{ROW_ITEM,  F_REF,  8'd0,   ADDR_LIMIT, 32'd0,         1'b1, W_FILL},
      '{ROW_ITEM,  F_REF,  8'd255, ADDR_LIMIT, 32'd0,         1'b1, W_FILL},
      '{ROW_ITEM,  F_REF,  8'd0,   ADDR_LIMIT, 32'd0,         1'b1, W_HIT},
      '{ROW_ITEM,  F_LIST, 8'd255, ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_WRITE, F_REF,  8'd0,   ADDR_LIMIT, 32'hFFFF_FFE3, 1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'd128, ADDR_LIMIT, 32'd0,         1'b1, W_FILL},
      '{ROW_ITEM,  F_REF,  8'd7,   ADDR_LIMIT, 32'd0,         1'b1, W_EV255},
      '{ROW_ITEM,  F_REF,  8'd9,   ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_WRITE, F_REF,  8'd0,   ADDR_LIMIT, 32'd1,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'd42,  ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_LIST, 8'd0,   ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_WRITE, F_REF,  8'd0,   ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'd42,  ADDR_LIMIT, 32'd0,         1'b1, W_HIT},
      '{ROW_WRITE, F_REF,  8'd0,   ADDR_SPARE, 32'd16,        1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'd77,  ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_LIST, 8'd0,   ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_WRITE, F_REF,  8'd0,   ADDR_LIMIT, 32'd31,        1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'd1,   ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_REF,  8'hAA,  ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN},
      '{ROW_ITEM,  F_LIST, 8'h55,  ADDR_LIMIT, 32'd0,         1'b0, W_PLAIN}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic                              req_func = lfu_pkg::FUNC_REF;
   logic [7:0]                        req_ref_id = 8'd0;
   logic                              rsp_strobe;
   logic                              rsp_hit;
   logic                              rsp_evicted;
   logic [lfu_pkg::OUT_ID_W-1:0]      rsp_evicted_id;
   logic [lfu_pkg::OUT_ID_W-1:0]      rsp_list_id;
   logic                              rsp_list_valid;
   logic                              rsp_last;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [lfu_pkg::CSR_AW-1:0]        paddr = '0;
   logic [lfu_pkg::CSR_DW-1:0]        pwdata = '0;
   logic [lfu_pkg::CSR_DW-1:0]        prdata;
   logic                              pready;

   // typed expectation riding along with the word being offered
   logic         pin_valid = 1'b0;
   rsp_word_type pin_word = W_PLAIN;

   // predictor state
   logic [7:0]                slot_id_m   [SLOTS];
   logic [lfu_pkg::USE_W-1:0] slot_cnt_m  [SLOTS];
   logic [3:0]                slot_rank_m [SLOTS];
   int                        fill_m = 0;
   logic [lfu_pkg::LIM_W-1:0] limit_m = lfu_pkg::LIM_RST;

   rsp_word_type due_words [$];
   rsp_word_type next_words [$];
   int           err_cnt = 0;
   int           word_cnt = 0;
   int unsigned  cyc_cnt = 0;

   lfu_slot_replacement dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_ref_id     (req_ref_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_list_id    (rsp_list_id),
      .rsp_list_valid (rsp_list_valid),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_word_type mk_word(input logic h, input logic e,
                                            input logic [7:0] eid, input logic [7:0] lid,
                                            input logic lv, input logic l);
      rsp_word_type w;
      w = '{h, e, eid, lid, lv, l};
      return w;
   endfunction

   function automatic int eff_limit();
      if (limit_m == '0) return 1;
      if (int'(limit_m) > SLOTS) return SLOTS;
      return int'(limit_m);
   endfunction

   // LFU table update and the words one item produces
   function automatic void lfu_predict_words(input logic f, input logic [7:0] id);
      int         v;
      int         hit_at;
      logic [3:0] r;
      logic [7:0] sorted [$];
      next_words.delete();
      if (f == lfu_pkg::FUNC_LIST) begin
         if (fill_m == 0) begin
            next_words.push_back(mk_word(1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
            return;
         end
         for (int i = 0; i < fill_m; i++) sorted.push_back(slot_id_m[i]);
         sorted.sort();
         foreach (sorted[k])
            next_words.push_back(mk_word(1'b0, 1'b0, 8'd0, sorted[k], 1'b1,
                                         k == sorted.size() - 1));
         return;
      end
      hit_at = -1;
      for (int i = 0; i < fill_m; i++)
         if (slot_id_m[i] == id) hit_at = i;
      if (hit_at >= 0) begin
         if (slot_cnt_m[hit_at] != lfu_pkg::USE_MAX)
            slot_cnt_m[hit_at] = slot_cnt_m[hit_at] + 1'b1;
         next_words.push_back(mk_word(1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
         return;
      end
      if (fill_m < eff_limit()) begin
         slot_id_m[fill_m]   = id;
         slot_cnt_m[fill_m]  = lfu_pkg::USE_ONE;
         slot_rank_m[fill_m] = 4'(fill_m);
         fill_m++;
         next_words.push_back(mk_word(1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
         return;
      end
      // victim: lowest count, oldest among equals
      v = 0;
      for (int i = 1; i < fill_m; i++)
         if (slot_cnt_m[i] < slot_cnt_m[v] ||
             (slot_cnt_m[i] == slot_cnt_m[v] && slot_rank_m[i] < slot_rank_m[v]))
            v = i;
      r = slot_rank_m[v];
      for (int i = 0; i < fill_m; i++)
         if (slot_rank_m[i] > r) slot_rank_m[i] = slot_rank_m[i] - 1'b1;
      next_words.push_back(mk_word(1'b0, 1'b1, slot_id_m[v], 8'd0, 1'b0, 1'b1));
      slot_id_m[v]   = id;
      slot_cnt_m[v]  = lfu_pkg::USE_ONE;
      slot_rank_m[v] = 4'(fill_m - 1);
   endfunction

   task automatic report_mismatch(input string msg);
      err_cnt++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // check result words, then predict for an accepted word
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_hit, rsp_evicted, rsp_evicted_id, rsp_list_id, rsp_list_valid,
                    rsp_last};
            if (due_words.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %0d: %p", word_cnt, got));
            end else begin
               want = due_words.pop_front();
               if (got.hit !== want.hit || got.evicted !== want.evicted ||
                   got.evicted_id !== want.evicted_id || got.list_id !== want.list_id ||
                   got.list_valid !== want.list_valid || got.last !== want.last)
                  report_mismatch($sformatf("word %0d: got %p want %p", word_cnt, got, want));
            end
            word_cnt++;
         end
         if (start && !busy) begin
            lfu_predict_words(req_func, req_ref_id);
            if (pin_valid) due_words.push_back(pin_word);
            else foreach (next_words[k]) due_words.push_back(next_words[k]);
         end
      end
   end

   always @(posedge clock) begin
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt == CYC_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input logic f, input logic [7:0] id, input logic pin,
                            input rsp_word_type pw, input int gap);
      start      <= 1'b1;
      req_func   <= f;
      req_ref_id <= id;
      pin_valid  <= pin;
      pin_word   <= pw;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_to_idle();
      start <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lfu_pkg::CSR_AW-1:0] a,
                            input logic [lfu_pkg::CSR_DW-1:0] d);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= a;
      pwdata  <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (a[lfu_pkg::CSR_AW-1:2] == lfu_pkg::CSR_IDX_LIMIT) limit_m = d[lfu_pkg::LIM_W-1:0];
   endtask

   task automatic csr_check_limit();
      logic [lfu_pkg::CSR_DW-1:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_LIMIT;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd[lfu_pkg::LIM_W-1:0] !== limit_m)
         report_mismatch($sformatf("slots_in_use read %0d want %0d",
                                   rd[lfu_pkg::LIM_W-1:0], limit_m));
   endtask

   initial begin
      int                         quiet;
      int                         r;
      int                         n_items;
      logic [lfu_pkg::CSR_DW-1:0] d;
      logic [7:0]                 pool [$];
      int                         lim_plan [9];

      lim_plan = '{16, 2, 31, 5, 1, 0, 12, 7, 16};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      csr_check_limit();

      for (int n = 0; n < N_DIR; n++) begin
         if (DIR_TAB[n].kind == ROW_WRITE) begin
            drain_to_idle();
            csr_write(DIR_TAB[n].addr, DIR_TAB[n].data);
            csr_check_limit();
         end else begin
            send_word(DIR_TAB[n].func, DIR_TAB[n].id, DIR_TAB[n].pin, DIR_TAB[n].want,
                      pick_gap(1'b0));
         end
      end

      foreach (lim_plan[p]) begin
         drain_to_idle();
         d = $urandom;
         d[lfu_pkg::LIM_W-1:0] = (p == 7) ? lfu_pkg::LIM_W'($urandom_range(1, SLOTS)) :
                                            lfu_pkg::LIM_W'(lim_plan[p]);
         csr_write(ADDR_LIMIT, d);
         csr_check_limit();
         if ($urandom_range(0, 3) == 0) csr_write(ADDR_SPARE, $urandom);
         quiet = ($urandom_range(0, 3) == 0);
         pool.delete();
         repeat (eff_limit() + 3) pool.push_back(8'($urandom));
         n_items = $urandom_range(12, 17);
         repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 12)
               send_word(lfu_pkg::FUNC_LIST, 8'($urandom), 1'b0, W_PLAIN, pick_gap(quiet));
            else if (r < 85)
               send_word(lfu_pkg::FUNC_REF, pool[$urandom_range(0, pool.size() - 1)], 1'b0,
                         W_PLAIN, pick_gap(quiet));
            else
               send_word(lfu_pkg::FUNC_REF, 8'($urandom), 1'b0, W_PLAIN, pick_gap(quiet));
         end
      end

      drain_to_idle();
      repeat (TAIL_WAIT) @(posedge clock);
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
